@@ rtl/core/lpfm_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfm_pkg
// Shared types and codes for the length-prefixed frame mailbox.
// ----------------------------------------------------------------------------
package lpfm_pkg;

  // Default payload capacity of the mailbox in bytes.
  localparam int unsigned BLOB_MAX_DEF = 256;

  // Command codes.
  localparam logic [1:0] CMD_FEED  = 2'd0;
  localparam logic [1:0] CMD_TAKE  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Result status codes.
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_BAD_LEN  = 3'd1;
  localparam logic [2:0] STS_FULL     = 3'd2;
  localparam logic [2:0] STS_NO_BLOB  = 3'd3;
  localparam logic [2:0] STS_TOO_LONG = 3'd4;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_STREAM
  } lpfm_state_e;

endpackage

@@ rtl/core/length_prefix_frame_mailbox_unit.sv @@
// ----------------------------------------------------------------------------
// length_prefix_frame_mailbox_unit
// Reassembles length-prefixed frames from a byte stream into a one-slot
// mailbox and streams the latched frame out in 64-bit words on a take.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | word carries
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o | cmd, data_byte, chunk_last,
//          |           |                         | buffer_limit
//  out     | source    | out_valid_o/out_stall_i | status, data_word, byte_count,
//          |           |                         | blob_length, last
//
// Feed, clear and unused commands complete without leaving ST_IDLE, so bytes
// stream in at one per cycle. A take that streams the frame holds the input
// until its last word is registered; the single read port of the payload
// memory delivers one 64-bit row per cycle while the output is not stalled.
// Reset clears all control state; the payload memory is not cleared. A stalled
// output holds the input whenever a result is waiting in the output register.

module length_prefix_frame_mailbox_unit
  import lpfm_pkg::*;
#(
  parameter int unsigned BLOB_MAX = BLOB_MAX_DEF,
  localparam int unsigned LW = $clog2(BLOB_MAX + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,

  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    cmd_i,
  input  logic [7:0]    data_byte_i,
  input  logic          chunk_last_i,
  input  logic [15:0]   buffer_limit_i,

  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    status_o,
  output logic [63:0]   data_word_o,
  output logic [3:0]    byte_count_o,
  output logic [LW-1:0] blob_length_o,
  output logic          last_o
);

  localparam int unsigned WORDS = (BLOB_MAX + 7) / 8;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned WW    = $clog2(WORDS + 1);

  // Payload memory: one 64-bit row per eight bytes, written a byte at a time.
  logic [63:0] mem_q [WORDS];
  logic [63:0] rdata_q;

  // Reassembly and mailbox state.
  logic [31:0]   prefix_q, prefix_d;
  logic [2:0]    pcount_q, pcount_d;
  logic [LW-1:0] expected_q, expected_d;
  logic [LW-1:0] received_q, received_d;
  logic          full_q, full_d;
  logic [LW-1:0] latched_q, latched_d;
  logic          open_q, open_d;
  logic          drop_q, drop_d;
  logic [1:0]    chunk_sts_q, chunk_sts_d;

  // Take sequencer.
  lpfm_state_e   state_q, state_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [WW-1:0] issue_left_q, issue_left_d;
  logic [LW-1:0] out_rem_q, out_rem_d;
  logic [LW-1:0] take_len_q, take_len_d;
  logic          rd_valid_q, rd_valid_d;

  // Output register.
  logic          out_valid_q, out_valid_d;
  logic [2:0]    status_q, status_d;
  logic [63:0]   word_q, word_d;
  logic [3:0]    count_q, count_d;
  logic [LW-1:0] blen_q, blen_d;
  logic          last_q, last_d;

  logic          out_free;
  logic          accept;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [2:0]    wr_lane;

  // Combinational scratch values.
  logic          drop_now;
  logic [1:0]    sts_now;
  logic [31:0]   pv_new;
  logic [LW-1:0] rcv_inc;
  logic [LW:0]   words_tmp;
  logic [LW-1:0] rcv_row;
  logic [3:0]    cnt;
  logic [63:0]   masked;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign rcv_row = received_q >> 3;
  assign wr_addr = rcv_row[AW-1:0];
  assign wr_lane = received_q[2:0];

  always_comb begin
    cnt = (out_rem_q >= LW'(8)) ? 4'd8 : out_rem_q[3:0];
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (4'(i) < cnt) ? rdata_q[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    prefix_d     = prefix_q;
    pcount_d     = pcount_q;
    expected_d   = expected_q;
    received_d   = received_q;
    full_d       = full_q;
    latched_d    = latched_q;
    open_d       = open_q;
    drop_d       = drop_q;
    chunk_sts_d  = chunk_sts_q;
    state_d      = state_q;
    rd_ptr_d     = rd_ptr_q;
    issue_left_d = issue_left_q;
    out_rem_d    = out_rem_q;
    take_len_d   = take_len_q;
    rd_valid_d   = rd_valid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    word_d       = word_q;
    count_d      = count_q;
    blen_d       = blen_q;
    last_d       = last_q;
    rd_en        = 1'b0;
    wr_en        = 1'b0;
    drop_now     = open_q ? drop_q : full_q;
    sts_now      = open_q ? chunk_sts_q : (full_q ? STS_FULL[1:0] : STS_OK[1:0]);
    pv_new       = prefix_q;
    rcv_inc      = received_q + LW'(1);
    words_tmp    = ({1'b0, latched_q} + (LW + 1)'(7)) >> 3;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_FEED: begin
              if (!drop_now) begin
                if (pcount_q < 3'd4) begin
                  case (pcount_q[1:0])
                    2'd0:    pv_new = prefix_q | {24'd0, data_byte_i};
                    2'd1:    pv_new = prefix_q | {16'd0, data_byte_i, 8'd0};
                    2'd2:    pv_new = prefix_q | {8'd0, data_byte_i, 16'd0};
                    default: pv_new = prefix_q | {data_byte_i, 24'd0};
                  endcase
                  prefix_d = pv_new;
                  pcount_d = pcount_q + 3'd1;
                  if (pcount_q == 3'd3) begin
                    if (pv_new == 32'd0 || pv_new > 32'(BLOB_MAX)) begin
                      prefix_d   = '0;
                      pcount_d   = '0;
                      expected_d = '0;
                      received_d = '0;
                      sts_now    = STS_BAD_LEN[1:0];
                      drop_now   = 1'b1;
                    end else begin
                      expected_d = pv_new[LW-1:0];
                    end
                  end
                end else begin
                  wr_en      = 1'b1;
                  received_d = rcv_inc;
                  if (rcv_inc >= expected_q) begin
                    latched_d  = expected_q;
                    full_d     = 1'b1;
                    prefix_d   = '0;
                    pcount_d   = '0;
                    expected_d = '0;
                    received_d = '0;
                    drop_now   = 1'b1;
                  end
                end
              end
              if (chunk_last_i) begin
                out_valid_d = 1'b1;
                status_d    = {1'b0, sts_now};
                word_d      = '0;
                count_d     = '0;
                blen_d      = '0;
                last_d      = 1'b1;
                open_d      = 1'b0;
                drop_d      = 1'b0;
                chunk_sts_d = STS_OK[1:0];
              end else begin
                open_d      = 1'b1;
                drop_d      = drop_now;
                chunk_sts_d = sts_now;
              end
            end
            CMD_TAKE: begin
              out_valid_d = 1'b1;
              word_d      = '0;
              count_d     = '0;
              last_d      = 1'b1;
              if (!full_q) begin
                status_d = STS_NO_BLOB;
                blen_d   = '0;
              end else begin
                full_d     = 1'b0;
                latched_d  = '0;
                prefix_d   = '0;
                pcount_d   = '0;
                expected_d = '0;
                received_d = '0;
                if (32'(latched_q) > 32'(buffer_limit_i)) begin
                  status_d = STS_TOO_LONG;
                  blen_d   = latched_q;
                end else begin
                  // The words follow from the memory; nothing is shown yet.
                  out_valid_d  = 1'b0;
                  state_d      = ST_STREAM;
                  rd_ptr_d     = '0;
                  issue_left_d = words_tmp[WW-1:0];
                  out_rem_d    = latched_q;
                  take_len_d   = latched_q;
                  rd_valid_d   = 1'b0;
                end
              end
            end
            CMD_CLEAR: begin
              prefix_d    = '0;
              pcount_d    = '0;
              expected_d  = '0;
              received_d  = '0;
              open_d      = 1'b0;
              drop_d      = 1'b0;
              chunk_sts_d = STS_OK[1:0];
            end
            default: begin
            end
          endcase
        end
      end
      ST_STREAM: begin
        // A new row is fetched only when rdata_q holds none or the one it holds leaves now.
        if (issue_left_q != '0 && (!rd_valid_q || out_free)) begin
          rd_en        = 1'b1;
          rd_ptr_d     = rd_ptr_q + AW'(1);
          issue_left_d = issue_left_q - WW'(1);
        end
        if (rd_valid_q && out_free) begin
          out_valid_d = 1'b1;
          status_d    = STS_OK;
          word_d      = masked;
          count_d     = cnt;
          blen_d      = take_len_q;
          last_d      = (out_rem_q <= LW'(8));
          out_rem_d   = out_rem_q - LW'(cnt);
          if (out_rem_q <= LW'(8)) begin
            state_d = ST_IDLE;
          end
        end
        if (rd_en) begin
          rd_valid_d = 1'b1;
        end else if (rd_valid_q && out_free) begin
          rd_valid_d = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prefix_q     <= '0;
      pcount_q     <= '0;
      expected_q   <= '0;
      received_q   <= '0;
      full_q       <= 1'b0;
      latched_q    <= '0;
      open_q       <= 1'b0;
      drop_q       <= 1'b0;
      chunk_sts_q  <= '0;
      rd_ptr_q     <= '0;
      issue_left_q <= '0;
      out_rem_q    <= '0;
      rd_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      prefix_q     <= prefix_d;
      pcount_q     <= pcount_d;
      expected_q   <= expected_d;
      received_q   <= received_d;
      full_q       <= full_d;
      latched_q    <= latched_d;
      open_q       <= open_d;
      drop_q       <= drop_d;
      chunk_sts_q  <= chunk_sts_d;
      rd_ptr_q     <= rd_ptr_d;
      issue_left_q <= issue_left_d;
      out_rem_q    <= out_rem_d;
      rd_valid_q   <= rd_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    take_len_q <= take_len_d;
    status_q   <= status_d;
    word_q     <= word_d;
    count_q    <= count_d;
    blen_q     <= blen_d;
    last_q     <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr][{wr_lane, 3'b000} +: 8] <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_ptr_q];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_word_o   = word_q;
  assign byte_count_o  = count_q;
  assign blob_length_o = blen_q;
  assign last_o        = last_q;

endmodule
